[hw/rtl/utf8_stream_decoder_core_assert.svh]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Property forms for the decoder back end, gated by an active-low reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define U8D_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8d: implication check failed");

// next-cycle implication
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8d: next-cycle check failed");

`endif

[hw/rtl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Item types, byte classes and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned CP_W    = 31;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned BITS_W  = 7;
    localparam int unsigned NARROW_W = 16;

    localparam logic [LEN_W-1:0] LEN_ASCII = 3'd1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] sequence_length;
    } t_out_item;

    typedef enum logic [1:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD
    } t_byte_class;

    // classified byte: lead bytes carry the continuation count still needed
    typedef struct packed {
        t_byte_class       cls;
        logic [LEN_W-1:0]  need;
        logic [BITS_W-1:0] bits;
        logic              end_of_text;
    } t_cls_item;

endpackage

[hw/rtl/u8d_front.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder front end
// Accepts text bytes, classifies them and holds one classified transfer.
// ----------------------------------------------------------------------------
module u8d_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  u8d_pkg::t_in_item  i_in_item,
    output logic               o_push,
    input  logic               i_queue_full,
    output u8d_pkg::t_cls_item o_item
);

    logic               r_valid;
    logic               n_valid;
    u8d_pkg::t_cls_item r_item;
    u8d_pkg::t_cls_item n_item;
    logic               accept;
    logic [7:0]         b;

    assign o_in_stall = r_valid && i_queue_full;
    assign o_push     = r_valid && !i_queue_full;
    assign o_item     = r_item;
    assign accept     = i_in_valid && !o_in_stall;
    assign b          = i_in_item.text_byte;

    always_comb begin
        n_item.end_of_text = i_in_item.end_of_text;
        n_item.cls         = u8d_pkg::CLS_LEAD;
        n_item.need        = '0;
        n_item.bits        = '0;
        if (!b[7]) begin
            n_item.cls  = u8d_pkg::CLS_ASCII;
            n_item.bits = b[6:0];
        end else if (!b[6]) begin
            n_item.cls  = u8d_pkg::CLS_CONT;
            n_item.bits = {1'b0, b[5:0]};
        end else if (!b[5]) begin
            n_item.need = 3'd1;
            n_item.bits = {2'b00, b[4:0]};
        end else if (!b[4]) begin
            n_item.need = 3'd2;
            n_item.bits = {3'b000, b[3:0]};
        end else if (!b[3]) begin
            n_item.need = 3'd3;
            n_item.bits = {4'b0000, b[2:0]};
        end else if (!b[2]) begin
            n_item.need = 3'd4;
            n_item.bits = {5'b00000, b[1:0]};
        end else begin
            n_item.need = 3'd5;
            n_item.bits = {6'b000000, b[0]};
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

[hw/rtl/u8d_queue.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder queue
// Short first-in first-out buffer of classified bytes between front and back.
// ----------------------------------------------------------------------------
module u8d_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u8d_pkg::t_cls_item i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output u8d_pkg::t_cls_item o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u8d_pkg::t_cls_item r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hw/rtl/u8d_back.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder back end
// Assembles code points from classified bytes and holds the result transfer.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_core_assert.svh"

module u8d_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_narrow,
    input  logic               i_q_valid,
    input  u8d_pkg::t_cls_item i_q_item,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output u8d_pkg::t_out_item o_out_item
);

    logic [2:0]         r_expected;
    logic [2:0]         r_total;
    logic [30:0]        r_partial;
    logic [2:0]         n_expected;
    logic [2:0]         n_total;
    logic [30:0]        n_partial;
    logic               r_out_valid;
    logic               n_out_valid;
    u8d_pkg::t_out_item r_out;
    u8d_pkg::t_out_item n_out;
    logic               done;
    logic [30:0]        value;
    logic [2:0]         done_len;
    logic [30:0]        shifted;

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign shifted     = {r_partial[24:0], i_q_item.bits[5:0]};

    always_comb begin
        n_expected = r_expected;
        n_total    = r_total;
        n_partial  = r_partial;
        done       = 1'b0;
        value      = '0;
        done_len   = '0;
        if (o_pop) begin
            if (i_q_item.cls == u8d_pkg::CLS_CONT && r_expected != '0) begin
                n_partial  = shifted;
                n_expected = r_expected - 1'b1;
                if (r_expected == 3'd1) begin
                    done       = 1'b1;
                    value      = shifted;
                    done_len   = r_total;
                    n_expected = '0;
                    n_total    = '0;
                    n_partial  = '0;
                end
            end else begin
                n_expected = '0;
                n_total    = '0;
                n_partial  = '0;
                case (i_q_item.cls)
                    u8d_pkg::CLS_ASCII: begin
                        done     = 1'b1;
                        value    = {24'd0, i_q_item.bits};
                        done_len = u8d_pkg::LEN_ASCII;
                    end
                    u8d_pkg::CLS_LEAD: begin
                        n_expected = i_q_item.need;
                        n_total    = i_q_item.need + 1'b1;
                        n_partial  = {24'd0, i_q_item.bits};
                    end
                    default: begin
                        // drop stray continuation
                    end
                endcase
            end
            if (i_q_item.end_of_text) begin
                n_expected = '0;
                n_total    = '0;
                n_partial  = '0;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (done) begin
            n_out_valid           = 1'b1;
            n_out.sequence_length = done_len;
            n_out.code_point      = i_narrow ? {15'd0, value[15:0]} : value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_expected  <= n_expected;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_partial <= n_partial;
        r_out     <= n_out;
    end

    `U8D_ASSERT_IMPL(a_open_total, i_clk, i_rst_n, r_expected != '0,
        r_total == r_expected + 3'd1 || r_total > r_expected + 3'd1)
    `U8D_ASSERT_IMPL(a_idle_clear, i_clk, i_rst_n, r_expected == '0, r_total == '0)
    `U8D_ASSERT_IMPL(a_len_range, i_clk, i_rst_n, r_out_valid,
        r_out.sequence_length != '0 && r_out.sequence_length != 3'd7)
    `U8D_ASSERT_NEXT(a_eot_idle, i_clk, i_rst_n, o_pop && i_q_item.end_of_text,
        r_expected == '0)
    `U8D_ASSERT_IMPL(a_no_pop_blocked, i_clk, i_rst_n, r_out_valid && i_out_stall, !o_pop)

endmodule

[hw/rtl/utf8_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Decodes six-byte-form UTF-8 into code points, one byte per unstalled cycle.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall    i_in_item  (t_in_item)
//   out      output     o_out_valid / i_out_stall  o_out_item (t_out_item)
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (narrow_output)
//
// One byte is taken per cycle unless the input stalls; a completed character
// passes front register, queue and output register after its last byte.
// Throughput is set by the back end, which updates its state on each pop.
// Reset is synchronous and active low; narrow_output resets to 1.
// Output stalls fill the queue first; the input stalls only once it is full.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  u8d_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output u8d_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    logic               r_narrow;
    logic               push;
    logic               full;
    logic               pop;
    logic               q_valid;
    u8d_pkg::t_cls_item front_item;
    u8d_pkg::t_cls_item q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_narrow <= i_cfg_data;
        end
    end

    u8d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_push       (push),
        .i_queue_full (full),
        .o_item       (front_item)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    u8d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_narrow    (r_narrow),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Streams directed and random six-byte-form UTF-8 text into the decoder under
// random sender bursts and receiver stalls, predicts every character and
// checks each output transfer in order, over both output widths.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CONT_TAG = 8'h80;
    localparam logic [7:0] LEAD2    = 8'hC0;
    localparam logic [7:0] LEAD3    = 8'hE0;
    localparam logic [7:0] LEAD4    = 8'hF0;
    localparam logic [7:0] LEAD5    = 8'hF8;
    localparam logic [7:0] LEAD6    = 8'hFC;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES = 8;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    u8d_pkg::t_in_item  i_in_item   = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               i_cfg_data  = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    u8d_pkg::t_out_item o_out_item;
    logic               o_cfg_ready;

    utf8_stream_decoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // decoder state as predicted
    logic                      narrow_mode = 1'b1;
    logic [u8d_pkg::LEN_W-1:0] seq_left    = '0;
    logic [u8d_pkg::LEN_W-1:0] seq_total   = '0;
    logic [u8d_pkg::CP_W-1:0]  seq_value   = '0;

    u8d_pkg::t_in_item  text_bytes[$];
    u8d_pkg::t_out_item expected_chars[$];
    u8d_pkg::t_out_item arrived_char;
    u8d_pkg::t_out_item predicted_char;
    int unsigned bytes_queued = 0;
    int unsigned errors       = 0;

    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;
    int unsigned stall_run  = 0;
    int unsigned stall_mode = 0;
    int unsigned cycle_no   = 0;

    function automatic bit decode_byte(input u8d_pkg::t_in_item it,
                                       output u8d_pkg::t_out_item ch);
        logic [7:0]                b;
        logic [u8d_pkg::LEN_W-1:0] len;
        logic [u8d_pkg::CP_W-1:0]  val;
        b   = it.text_byte;
        len = '0;
        val = '0;
        ch  = '0;
        if (seq_left != 0 && b[7:6] == 2'b10) begin
            seq_value = {seq_value[u8d_pkg::CP_W-7:0], b[5:0]};
            seq_left  = seq_left - 1'b1;
            if (seq_left == 0) begin
                len = seq_total;
                val = seq_value;
            end
        end else begin
            seq_left  = '0;
            seq_total = '0;
            seq_value = '0;
            if (b < CONT_TAG) begin
                len = u8d_pkg::LEN_ASCII;
                val = u8d_pkg::CP_W'(b);
            end else if (b >= LEAD2) begin
                if (b < LEAD3) begin
                    seq_left  = 3'd1;
                    seq_value = u8d_pkg::CP_W'(b[4:0]);
                end else if (b < LEAD4) begin
                    seq_left  = 3'd2;
                    seq_value = u8d_pkg::CP_W'(b[3:0]);
                end else if (b < LEAD5) begin
                    seq_left  = 3'd3;
                    seq_value = u8d_pkg::CP_W'(b[2:0]);
                end else if (b < LEAD6) begin
                    seq_left  = 3'd4;
                    seq_value = u8d_pkg::CP_W'(b[1:0]);
                end else begin
                    seq_left  = 3'd5;
                    seq_value = u8d_pkg::CP_W'(b[0]);
                end
                seq_total = seq_left + 1'b1;
            end
        end
        if (len != 0 || it.end_of_text) begin
            seq_left  = '0;
            seq_total = '0;
            seq_value = '0;
        end
        if (len == 0)
            return 1'b0;
        if (narrow_mode)
            val[u8d_pkg::CP_W-1:u8d_pkg::NARROW_W] = '0;
        ch.code_point      = val;
        ch.sequence_length = len;
        return 1'b1;
    endfunction

    // driver: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (decode_byte(i_in_item, predicted_char))
                    expected_chars.push_back(predicted_char);
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (text_bytes.size() != 0) begin
                    i_in_item  <= text_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 5) == 0) begin
                            burst_left = 80;
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = $urandom_range(1, 12);
                        end
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        cycle_no++;
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(8, 60);
        end else begin
            stall_run--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= 1'($urandom_range(0, 1));
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (cycle_no % 8 < 3);
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character, expected none, actual %h/%0d",
                         $time, o_out_item.code_point, o_out_item.sequence_length);
                errors++;
            end else begin
                arrived_char = expected_chars.pop_front();
                if (o_out_item.code_point !== arrived_char.code_point) begin
                    $display("%0t: code_point expected %h actual %h",
                             $time, arrived_char.code_point, o_out_item.code_point);
                    errors++;
                end
                if (o_out_item.sequence_length !== arrived_char.sequence_length) begin
                    $display("%0t: sequence_length expected %0d actual %0d", $time,
                             arrived_char.sequence_length, o_out_item.sequence_length);
                    errors++;
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic eot);
        u8d_pkg::t_in_item it;
        it.text_byte   = b;
        it.end_of_text = eot;
        text_bytes.push_back(it);
        bytes_queued++;
    endtask

    function automatic logic [7:0] lead_byte(input int unsigned len);
        case (len)
            1:       return 8'($urandom_range(0, 127));
            2:       return LEAD2 | 8'($urandom_range(0, 31));
            3:       return LEAD3 | 8'($urandom_range(0, 15));
            4:       return LEAD4 | 8'($urandom_range(0, 7));
            5:       return LEAD5 | 8'($urandom_range(0, 3));
            default: return LEAD6 | 8'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic push_char(input int unsigned len, input logic eot);
        push_byte(lead_byte(len), eot && len == 1);
        for (int unsigned k = 1; k < len; k++)
            push_byte(CONT_TAG | 8'($urandom_range(0, 63)), eot && k == len - 1);
    endtask

    task automatic queue_text(input int unsigned n);
        int unsigned  stop;
        int unsigned  pick;
        int unsigned  len;
        int unsigned  part;
        logic [7:0]   b;
        stop = bytes_queued + n;
        while (bytes_queued < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                push_char($urandom_range(1, 6), $urandom_range(0, 19) == 0);
            end else if (pick < 85) begin
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end else if (pick < 95) begin
                // broken sequence: cut by end of text or by a fresh start
                len  = $urandom_range(2, 6);
                part = $urandom_range(0, len - 2);
                if ($urandom_range(0, 2) == 0) begin
                    push_byte(lead_byte(len), part == 0);
                    for (int unsigned k = 1; k <= part; k++)
                        push_byte(CONT_TAG | 8'($urandom_range(0, 63)), k == part);
                end else begin
                    push_byte(lead_byte(len), 1'b0);
                    for (int unsigned k = 1; k <= part; k++)
                        push_byte(CONT_TAG | 8'($urandom_range(0, 63)), 1'b0);
                    b = 8'($urandom_range(0, 255));
                    if (b[7:6] == 2'b10)
                        b[7] = 1'b0;
                    push_byte(b, 1'b0);
                end
            end else begin
                push_byte(CONT_TAG | 8'($urandom_range(0, 63)),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic queue_directed();
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hC0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hDF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hEF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hFF, 1'b0);
        repeat (5) push_byte(8'hBF, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'hE0, 1'b0);
        push_byte(8'hC2, 1'b0);
        push_byte(8'hA9, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b1);
        push_byte(8'hC2, 1'b0);
        push_byte(8'hA9, 1'b1);
    endtask

    task automatic wait_drained();
        int unsigned waited;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while ((text_bytes.size() != 0 || i_in_valid || expected_chars.size() != 0)
                   && waited < DRAIN_LIMIT);
        if (expected_chars.size() != 0) begin
            $display("%0t: %0d characters expected, none arrived",
                     $time, expected_chars.size());
            errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_narrow(input logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        narrow_mode = v;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_text(100);
        wait_drained();

        write_narrow(1'b0);
        queue_directed();
        queue_text(500);
        wait_drained();

        write_narrow(1'b1);
        queue_text(400);
        wait_drained();

        write_narrow(1'b0);
        queue_text(450);
        wait_drained();

        if (errors == 0 && expected_chars.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
